// ----- rtl/brf_pkg.sv -----
// Shared types, codes and ring arithmetic for the byte ring FIFO.
// Used by brf_front, brf_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brf_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int MAX_RUN    = 64;

  localparam logic [3:0] OPC_PUSH       = 4'd0;
  localparam logic [3:0] OPC_POP        = 4'd1;
  localparam logic [3:0] OPC_PEEK       = 4'd2;
  localparam logic [3:0] OPC_CLEAR      = 4'd3;
  localparam logic [3:0] OPC_FIRST      = 4'd4;
  localparam logic [3:0] OPC_LAST       = 4'd5;
  localparam logic [3:0] OPC_POP_RUN    = 4'd6;
  localparam logic [3:0] OPC_PEEK_RUN   = 4'd7;
  localparam logic [3:0] OPC_POP_TO_MK  = 4'd8;
  localparam logic [3:0] OPC_PEEK_TO_MK = 4'd9;

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  localparam logic REG_OVERWRITE = 1'b0;
  localparam logic REG_CAPACITY  = 1'b1;

  typedef enum logic [2:0] {
    K_PUSH, K_READ, K_CLEAR, K_FIRST, K_LAST, K_RUN, K_RUN_MARK, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        drop;
    logic [7:0]  push_byte;
    logic [7:0]  marker;
    logic [6:0]  run_count;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b,
                                                 input logic [ADDR_W:0]   len);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= len) s = s - len;
    return s[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/brf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/brf_front.sv -----
// Input side: accepts operations, classifies the opcode, queues up to two commands.
// Depends on brf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module brf_front
  import brf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] opcode,
  input  wire logic [7:0] push_byte,
  input  wire logic [7:0] marker,
  input  wire logic [6:0] run_count,
  output logic            cmd_valid,
  input  wire logic       cmd_ready,
  output cmd_t            cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       incoming;
  logic       push_q;
  logic       pop_q;

  always_comb begin
    incoming.push_byte = push_byte;
    incoming.marker    = marker;
    incoming.run_count = run_count;
    incoming.drop      = 1'b0;
    unique case (opcode)
      OPC_PUSH:       incoming.kind = K_PUSH;
      OPC_POP:        begin incoming.kind = K_READ; incoming.drop = 1'b1; end
      OPC_PEEK:       incoming.kind = K_READ;
      OPC_CLEAR:      incoming.kind = K_CLEAR;
      OPC_FIRST:      incoming.kind = K_FIRST;
      OPC_LAST:       incoming.kind = K_LAST;
      OPC_POP_RUN:    begin incoming.kind = K_RUN; incoming.drop = 1'b1; end
      OPC_PEEK_RUN:   incoming.kind = K_RUN;
      OPC_POP_TO_MK:  begin incoming.kind = K_RUN_MARK; incoming.drop = 1'b1; end
      OPC_PEEK_TO_MK: incoming.kind = K_RUN_MARK;
      default:        incoming.kind = K_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];
  assign push_q    = in_valid && in_ready;
  assign pop_q     = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_q) begin
        entries[wr_ptr] <= incoming;
        wr_ptr <= ~wr_ptr;
      end
      if (pop_q) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push_q) - 2'(pop_q);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/brf_back.sv -----
// Execution side: ring positions, configuration, marker scan, runs, result register.
// Depends on brf_pkg and brf_ram.
`timescale 1ns / 1ps
`default_nettype none
module brf_back
  import brf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire cmd_t       cmd,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [7:0]      read_byte,
  output logic [7:0]      span_length,
  output logic [7:0]      occupancy,
  output logic [7:0]      free_space,
  output logic            last
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_RD_ISSUE, S_RD_WAIT, S_EMIT
  } state_t;

  state_t            state;
  cmd_t              op;
  logic [ADDR_W-1:0] rp;
  logic [ADDR_W-1:0] wp;
  logic              ow;
  logic [7:0]        cap;
  logic [1:0]        res_status;
  logic [7:0]        res_span;
  logic [7:0]        scan_k;
  logic [7:0]        cmp_k;
  logic              cmp_valid;
  logic [7:0]        first_span;
  logic [7:0]        last_span;
  logic [7:0]        avail;
  logic [ADDR_W-1:0] run_base;
  logic [6:0]        run_len;
  logic [6:0]        k;

  logic [ADDR_W:0]   len;
  logic [ADDR_W:0]   occ_w;
  logic [7:0]        occ;
  logic [7:0]        free_now;
  logic              full;
  logic [ADDR_W-1:0] wp_adv;
  logic [ADDR_W-1:0] wp_adv2;
  logic              out_free;
  logic              out_load;
  logic              we;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic [7:0]        cap_next;

  always_comb begin
    len = {1'b0, cap} + (ADDR_W + 1)'(1);
    if (wp >= rp) occ_w = {1'b0, wp} - {1'b0, rp};
    else          occ_w = len - ({1'b0, rp} - {1'b0, wp});
    occ      = occ_w[7:0];
    free_now = cap - occ;
    full     = (occ == cap);
    wp_adv   = wrap_add(wp, ADDR_W'(1), len);
    wp_adv2  = wrap_add(wp_adv, ADDR_W'(1), len);
    out_free = !out_valid || out_ready;
    out_load = out_free && (state == S_RD_WAIT || state == S_EMIT);
    we = (state == S_IDLE) && cmd_valid && (cmd.kind == K_PUSH) && !(full && !ow);
    re    = 1'b0;
    raddr = rp;
    if (state == S_SCAN && scan_k < occ) begin
      re    = 1'b1;
      raddr = wrap_add(rp, scan_k, len);
    end else if (state == S_RD_ISSUE) begin
      re    = 1'b1;
      raddr = wrap_add(run_base, ADDR_W'(k), len);
    end
    cap_next = cfg_data;
    if (cap_next == 8'd0) cap_next = 8'd1;
    if ({1'b0, cap_next} > 9'(SLOT_COUNT - 1)) cap_next = 8'(SLOT_COUNT - 1);
  end

  assign cmd_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  brf_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (cmd.push_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rp        <= '0;
      wp        <= '0;
      ow        <= 1'b0;
      cap       <= 8'(SLOT_COUNT - 1);
      cmp_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_OVERWRITE: ow <= cfg_data[0];
          REG_CAPACITY: begin
            cap <= cap_next;
            rp  <= '0;
            wp  <= '0;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op       <= cmd;
            res_span <= 8'd0;
            unique case (cmd.kind)
              K_PUSH: begin
                if (!(full && !ow)) begin
                  wp <= wp_adv;
                  if (full) rp <= wp_adv2;
                end
                res_status <= full ? ST_FULL : ST_NORMAL;
                state      <= S_EMIT;
              end
              K_READ: begin
                if (occ == 8'd0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  run_base <= rp;
                  run_len  <= 7'd1;
                  k        <= 7'd0;
                  if (cmd.drop) rp <= wrap_add(rp, ADDR_W'(1), len);
                  state    <= S_RD_ISSUE;
                end
              end
              K_CLEAR: begin
                rp         <= '0;
                wp         <= '0;
                res_status <= ST_NORMAL;
                state      <= S_EMIT;
              end
              K_FIRST, K_LAST, K_RUN_MARK: begin
                scan_k     <= 8'd0;
                cmp_valid  <= 1'b0;
                first_span <= 8'd0;
                last_span  <= 8'd0;
                state      <= S_SCAN;
              end
              K_RUN: begin
                avail <= occ;
                state <= S_DECIDE;
              end
              default: begin
                res_status <= ST_NORMAL;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_k < occ) begin
            scan_k    <= scan_k + 8'd1;
            cmp_k     <= scan_k;
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid && rdata == op.marker) begin
            last_span <= cmp_k + 8'd1;
            if (first_span == 8'd0) first_span <= cmp_k + 8'd1;
          end
          if (scan_k == occ && !cmp_valid) begin
            res_status <= ST_NORMAL;
            priority case (op.kind)
              K_FIRST: begin res_span <= first_span; state <= S_EMIT; end
              K_LAST:  begin res_span <= last_span;  state <= S_EMIT; end
              default: begin avail <= last_span; state <= S_DECIDE; end
            endcase
          end
        end
        S_DECIDE: begin
          if (op.run_count > 7'(MAX_RUN) || avail < {1'b0, op.run_count}) begin
            res_status <= ST_ERROR;
            state      <= S_EMIT;
          end else if (op.run_count == 7'd0) begin
            res_status <= ST_NORMAL;
            state      <= S_EMIT;
          end else begin
            run_base <= rp;
            run_len  <= op.run_count;
            k        <= 7'd0;
            if (op.drop) rp <= wrap_add(rp, ADDR_W'(op.run_count), len);
            state    <= S_RD_ISSUE;
          end
        end
        S_RD_ISSUE: state <= S_RD_WAIT;
        S_RD_WAIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= ST_NORMAL;
            read_byte   <= rdata;
            span_length <= 8'd0;
            occupancy   <= occ;
            free_space  <= free_now;
            last        <= (k == run_len - 7'd1);
            if (k == run_len - 7'd1) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 7'd1;
              state <= S_RD_ISSUE;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            read_byte   <= 8'd0;
            span_length <= res_span;
            occupancy   <= occ;
            free_space  <= free_now;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/byte_ring_fifo_with_separator_search.sv -----
// Top level of the byte ring FIFO with marker search.
// Depends on brf_pkg, brf_front, brf_back (and brf_ram through brf_back).
//
//   channel  handshake             payload
//   in       in_valid / in_ready   opcode, push_byte, marker, run_count
//   out      out_valid / out_ready status, read_byte, span_length, occupancy,
//                                  free_space, last
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Push, clear and unused opcodes go straight to the result; pop and peek add a registered RAM read.
// Plain runs go straight to the result when refused or empty, else read and emit their bytes one by one.
// Marker queries scan every byte held; runs to a marker do such a scan before the plain
// run handling above.
// Reset is synchronous; the ring starts empty with capacity 255, lock mode.
// A two-entry command queue keeps accepting input while the result stalls, until both entries are held.
`timescale 1ns / 1ps
`default_nettype none
module byte_ring_fifo_with_separator_search
  import brf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] opcode,
  input  wire logic [7:0] push_byte,
  input  wire logic [7:0] marker,
  input  wire logic [6:0] run_count,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [7:0]      read_byte,
  output logic [7:0]      span_length,
  output logic [7:0]      occupancy,
  output logic [7:0]      free_space,
  output logic            last
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  brf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .push_byte (push_byte),
    .marker    (marker),
    .run_count (run_count),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  brf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_byte   (read_byte),
    .span_length (span_length),
    .occupancy   (occupancy),
    .free_space  (free_space),
    .last        (last)
  );

endmodule
`default_nettype wire

// ----- verif/tb_byte_ring_fifo_with_separator_search.sv -----
// Testbench for byte_ring_fifo_with_separator_search: directed and random
// FIFO traffic checked against an in-bench ring model. Depends on brf_pkg.
`timescale 1ns / 1ps
module tb_byte_ring_fifo_with_separator_search;
  import brf_pkg::*;

  localparam logic [3:0] OPC_UNUSED = 4'd15;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0] st;
    logic [7:0] rb;
    logic [7:0] span;
    logic [7:0] occ;
    logic [7:0] free;
    logic       fin;
  } fifo_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] opcode = '0;
  logic [7:0] push_byte = '0;
  logic [7:0] marker = '0;
  logic [6:0] run_count = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_OVERWRITE;
  logic [7:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [7:0] read_byte, span_length, occupancy, free_space;
  logic last;

  byte_ring_fifo_with_separator_search uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0] ring_bytes [SLOT_COUNT];
  int rd_pos = 0, wr_pos = 0, cap_bytes = 255;
  bit ovw_mode = 1'b0;
  fifo_result_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;

  function automatic int ring_fill();
    return (wr_pos >= rd_pos) ? wr_pos - rd_pos : cap_bytes + 1 - (rd_pos - wr_pos);
  endfunction

  function automatic int ring_next(int p);
    return (p + 1 >= cap_bytes + 1) ? 0 : p + 1;
  endfunction

  function automatic logic [7:0] ring_at(int k);
    int idx;
    idx = rd_pos + k;
    if (idx >= cap_bytes + 1) idx -= cap_bytes + 1;
    return ring_bytes[idx];
  endfunction

  function automatic int span_to_last(logic [7:0] mk);
    for (int k = ring_fill(); k > 0; k--) if (ring_at(k - 1) == mk) return k;
    return 0;
  endfunction

  function automatic void expect_result(logic [1:0] st, logic [7:0] rb, logic [7:0] span,
                                        logic fin);
    fifo_result_t r;
    r.st = st; r.rb = rb; r.span = span;
    r.occ = 8'(ring_fill()); r.free = 8'(cap_bytes - ring_fill()); r.fin = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void apply_fifo_op(logic [3:0] op, logic [7:0] pb, logic [7:0] mk,
                                        logic [6:0] cnt);
    int avail, span;
    bit full;
    logic [7:0] taken [MAX_RUN];
    case (op)
      OPC_PUSH: begin
        full = (ring_fill() == cap_bytes);
        if (full && !ovw_mode) begin
          expect_result(ST_FULL, 0, 0, 1);
        end else begin
          ring_bytes[wr_pos] = pb;
          wr_pos = ring_next(wr_pos);
          if (full) rd_pos = ring_next(wr_pos);
          expect_result(full ? ST_FULL : ST_NORMAL, 0, 0, 1);
        end
      end
      OPC_POP, OPC_PEEK: begin
        if (ring_fill() == 0) begin
          expect_result(ST_EMPTY, 0, 0, 1);
        end else begin
          taken[0] = ring_at(0);
          if (op == OPC_POP) rd_pos = ring_next(rd_pos);
          expect_result(ST_NORMAL, taken[0], 0, 1);
        end
      end
      OPC_CLEAR: begin
        rd_pos = 0; wr_pos = 0;
        expect_result(ST_NORMAL, 0, 0, 1);
      end
      OPC_FIRST: begin
        span = 0;
        for (int k = 0; k < ring_fill(); k++)
          if (span == 0 && ring_at(k) == mk) span = k + 1;
        expect_result(ST_NORMAL, 0, 8'(span), 1);
      end
      OPC_LAST: expect_result(ST_NORMAL, 0, 8'(span_to_last(mk)), 1);
      OPC_POP_RUN, OPC_PEEK_RUN, OPC_POP_TO_MK, OPC_PEEK_TO_MK: begin
        avail = (op == OPC_POP_TO_MK || op == OPC_PEEK_TO_MK) ? span_to_last(mk) : ring_fill();
        if (cnt > MAX_RUN || avail < cnt) begin
          expect_result(ST_ERROR, 0, 0, 1);
        end else if (cnt == 0) begin
          expect_result(ST_NORMAL, 0, 0, 1);
        end else begin
          for (int k = 0; k < cnt; k++) taken[k] = ring_at(k);
          if (op == OPC_POP_RUN || op == OPC_POP_TO_MK)
            for (int k = 0; k < cnt; k++) rd_pos = ring_next(rd_pos);
          for (int k = 0; k < cnt; k++) expect_result(ST_NORMAL, taken[k], 0, k + 1 == cnt);
        end
      end
      default: expect_result(ST_NORMAL, 0, 0, 1);
    endcase
  endfunction

  task automatic send_op(logic [3:0] op, logic [7:0] pb = 0, logic [7:0] mk = 0,
                         logic [6:0] cnt = 0);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op; push_byte <= pb; marker <= mk; run_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_fifo_op(op, pb, mk, cnt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    drain();
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_OVERWRITE) begin
      ovw_mode = data[0];
    end else begin
      cap_bytes = (data == 0) ? 1 : int'(data);
      rd_pos = 0; wr_pos = 0;
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'h0A;
      1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_item();
    int r, c;
    logic [3:0] op;
    logic [6:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 40) op = OPC_PUSH;
    else if (r < 50) op = OPC_POP;
    else if (r < 55) op = OPC_PEEK;
    else if (r < 58) op = OPC_CLEAR;
    else if (r < 64) op = OPC_FIRST;
    else if (r < 70) op = OPC_LAST;
    else if (r < 78) op = OPC_POP_RUN;
    else if (r < 84) op = OPC_PEEK_RUN;
    else if (r < 91) op = OPC_POP_TO_MK;
    else if (r < 97) op = OPC_PEEK_TO_MK;
    else op = 4'($urandom_range(10, 15));
    c = $urandom_range(0, 9);
    if (c < 7) cnt = 7'($urandom_range(0, 6));
    else if (c < 9) cnt = (ring_fill() > MAX_RUN) ? 7'(MAX_RUN) : 7'($urandom_range(0, ring_fill()));
    else cnt = 7'($urandom_range(0, 127));
    send_op(op, pick_byte(), pick_byte(), cnt);
  endtask

  task automatic test_empty_queue();
    send_op(OPC_POP);
    send_op(OPC_PEEK);
    send_op(OPC_POP_RUN, 0, 0, 0);
    send_op(OPC_PEEK_RUN, 0, 0, 1);
    send_op(OPC_FIRST, 0, 8'h0A);
    send_op(OPC_LAST, 0, 8'h0A);
    send_op(OPC_PEEK_TO_MK, 0, 8'h0A, 1);
    send_op(OPC_UNUSED, 8'hFF, 8'hFF, 7'h7F);
    send_op(OPC_CLEAR);
    drain();
  endtask

  task automatic test_full_modes();
    write_reg(REG_CAPACITY, 8'd0);
    send_op(OPC_PUSH, 8'h5A);
    send_op(OPC_PUSH, 8'hA5);
    write_reg(REG_OVERWRITE, 8'h01);
    write_reg(REG_CAPACITY, 8'd3);
    send_op(OPC_PUSH, 8'h00);
    send_op(OPC_PUSH, 8'h0A);
    send_op(OPC_PUSH, 8'hFF);
    send_op(OPC_PUSH, 8'h0A);
    send_op(OPC_FIRST, 0, 8'h0A);
    send_op(OPC_LAST, 0, 8'h0A);
    send_op(OPC_PEEK_RUN, 0, 0, 3);
    send_op(OPC_PEEK_RUN, 0, 0, 4);
    send_op(OPC_POP_RUN, 0, 0, 7'd65);
    send_op(OPC_POP_TO_MK, 0, 8'hFF, 3);
    send_op(OPC_PEEK_TO_MK, 0, 8'h0A, 3);
    send_op(OPC_POP_TO_MK, 0, 8'h0A, 3);
    drain();
    write_reg(REG_OVERWRITE, 8'hFE);
  endtask

  task automatic test_backpressure();
    write_reg(REG_CAPACITY, 8'd255);
    hold_req = 1'b1;
    repeat (24) send_op(OPC_PUSH, 8'($urandom_range(0, 255)));
    send_op(OPC_POP_RUN, 0, 0, 7'd64);
    drain();
  endtask

  task automatic test_random_phase(bit mode, logic [7:0] cap, int items, bit no_gaps);
    write_reg(REG_OVERWRITE, {7'($urandom_range(0, 127)), mode});
    write_reg(REG_CAPACITY, cap);
    quiet = no_gaps;
    repeat (items) random_item();
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_full_modes();
    test_backpressure();
    test_random_phase(1'b0, 8'd4, 20, 1'b0);
    test_random_phase(1'b1, 8'd4, 20, 1'b1);
    test_random_phase(1'b1, 8'd1, 15, 1'b0);
    test_random_phase(1'b0, 8'd255, 20, 1'b0);
    test_random_phase(1'b1, 8'd255, 15, 1'b0);
    test_random_phase(1'b0, 8'($urandom_range(0, 255)), 20, 1'b0);
    test_random_phase(1'b1, 8'($urandom_range(8, 40)), 20, 1'b1);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int n;
    fifo_result_t e;
    @(negedge rst);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 5);
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.st) begin
          $error("status expected %0d got %0d", e.st, status); mismatches++;
        end
        if (read_byte !== e.rb) begin
          $error("read_byte expected %0d got %0d", e.rb, read_byte); mismatches++;
        end
        if (span_length !== e.span) begin
          $error("span_length expected %0d got %0d", e.span, span_length); mismatches++;
        end
        if (occupancy !== e.occ) begin
          $error("occupancy expected %0d got %0d", e.occ, occupancy); mismatches++;
        end
        if (free_space !== e.free) begin
          $error("free_space expected %0d got %0d", e.free, free_space); mismatches++;
        end
        if (last !== e.fin) begin
          $error("last expected %0d got %0d", e.fin, last); mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
